@@ hdl/sfd_pkg.sv @@
// shared types and constants of the stereo feedback delay
package sfd_pkg;

    localparam int SAMPLE_W  = 24;
    localparam int STORE_W   = 26;
    localparam int TAB_W     = 24;
    localparam int CFG_W     = 18;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_DELAY    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FEEDBACK = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DAMPING  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIX      = 2'd3;

    localparam int DAMP_SCALE = 55706;
    localparam int FB_MAX     = 62259;
    localparam int UNITY      = 65536;

    typedef struct packed {
        logic        rd_en;
        logic        st_rd;
        logic        st_lp;
        logic        st_fb;
        logic        st_th;
        logic        st_ip;
        logic        wr_en;
        logic        vld;
        logic [15:0] coeff;
        logic [15:0] fb;
        logic [16:0] mix;
    } lane_ctrl_t;

    typedef struct packed {
        logic             we;
        logic [TAB_W-1:0] data;
    } tab_wr_t;

endpackage

@@ hdl/sfd_in_if.sv @@
// input channel: one stereo pair per word
interface sfd_in_if import sfd_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] left_in;
    logic signed [SAMPLE_W-1:0] right_in;

    modport source (output valid, output left_in, output right_in, input ready);
    modport sink (input valid, input left_in, input right_in, output ready);
endinterface

@@ hdl/sfd_out_if.sv @@
// output channel: one mixed stereo pair per word
interface sfd_out_if import sfd_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] left_out;
    logic signed [SAMPLE_W-1:0] right_out;

    modport source (output valid, output left_out, output right_out, input ready);
    modport sink (input valid, input left_out, input right_out, output ready);
endinterface

@@ hdl/sfd_ram.sv @@
// generic single write port ram with registered read
module sfd_ram #(
    parameter int WIDTH = 26,
    parameter int DEPTH = 1024
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic                                    re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

@@ hdl/sfd_tanh_gen.sv @@
// builds the tanh table after reset, one entry per serial divide and multiply
module sfd_tanh_gen import sfd_pkg::*; #(
    parameter int TANH_TABLE_SIZE = 1024
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    output tab_wr_t                                tab_wr,
    output logic [$clog2(TANH_TABLE_SIZE+1)-1:0]   tab_k,
    output logic [TAB_W-1:0]                       tmax,
    output logic                                   done
);
    localparam int KW = $clog2(TANH_TABLE_SIZE + 1);

    // exp(-8/n) as a q40 series, evaluated at elaboration
    function automatic logic [63:0] exp_q40(input int n_sz);
        logic [63:0] term;
        logic [63:0] r;
        logic [63:0] d;
        logic [63:0] num;
        logic [63:0] q;
        logic [64:0] rem;
        term = 64'd1 << 40;
        r    = 64'd1 << 40;
        for (int n = 1; n <= 24; n++)
        begin
            d   = 64'(n_sz) * 64'(n);
            num = (term << 3) + (d >> 1);
            q   = '0;
            rem = '0;
            for (int b = 63; b >= 0; b--)
            begin
                rem = {rem[63:0], num[b]};
                if (rem >= 65'(d))
                begin
                    rem  = rem - 65'(d);
                    q[b] = 1'b1;
                end
            end
            term = q;
            if ((n % 2) == 1)
            begin
                r = r - term;
            end
            else
            begin
                r = r + term;
            end
        end
        return r;
    endfunction

    localparam logic [63:0] R_Q40 = exp_q40(TANH_TABLE_SIZE);
    localparam logic [19:0] R_HI  = R_Q40[39:20];
    localparam logic [19:0] R_LO  = R_Q40[19:0];

    localparam logic [2:0] G_LOAD = 3'd0;
    localparam logic [2:0] G_DIV  = 3'd1;
    localparam logic [2:0] G_PUT  = 3'd2;
    localparam logic [2:0] G_MUL  = 3'd3;
    localparam logic [2:0] G_EXP  = 3'd4;
    localparam logic [2:0] G_DONE = 3'd5;

    logic [2:0]       st_reg;
    logic [40:0]      e_reg;
    logic [KW-1:0]    k_reg;
    logic [5:0]       cnt_reg;
    logic [63:0]      dvd_reg;
    logic [41:0]      den_reg;
    logic [41:0]      rem_reg;
    logic [TAB_W-1:0] q_reg;
    logic [60:0]      a_reg;
    logic [60:0]      acch_reg;
    logic [60:0]      accl_reg;
    logic [TAB_W-1:0] tmax_reg;

    logic [41:0] den_w;
    logic [41:0] num_w;
    logic [42:0] rem_sh;
    logic        take;
    logic [60:0] e_sum;

    assign den_w  = 42'(1) << 40;
    assign num_w  = (42'(1) << 40) - 42'(e_reg);
    assign rem_sh = {rem_reg, dvd_reg[63]};
    assign take   = rem_sh >= 43'(den_reg);
    assign e_sum  = acch_reg + (accl_reg >> 20);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg  <= G_LOAD;
            e_reg   <= 41'(1) << 40;
            k_reg   <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            unique case (st_reg)
                G_LOAD:
                begin
                    cnt_reg <= '0;
                    st_reg  <= G_DIV;
                end
                G_DIV:
                begin
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd63)
                    begin
                        st_reg <= G_PUT;
                    end
                end
                G_PUT:
                begin
                    cnt_reg <= '0;
                    if (k_reg == KW'(TANH_TABLE_SIZE))
                    begin
                        st_reg <= G_DONE;
                    end
                    else
                    begin
                        st_reg <= G_MUL;
                    end
                end
                G_MUL:
                begin
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd19)
                    begin
                        st_reg <= G_EXP;
                    end
                end
                G_EXP:
                begin
                    e_reg  <= 41'(e_sum >> 20);
                    k_reg  <= k_reg + KW'(1);
                    st_reg <= G_LOAD;
                end
                G_DONE:
                begin
                    st_reg <= G_DONE;
                end
                default:
                begin
                    st_reg <= G_LOAD;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (st_reg)
            G_LOAD:
            begin
                den_reg <= den_w + 42'(e_reg);
                dvd_reg <= (64'(num_w) << 23) + 64'((den_w + 42'(e_reg)) >> 1);
                rem_reg <= '0;
                q_reg   <= '0;
            end
            G_DIV:
            begin
                dvd_reg <= dvd_reg << 1;
                if (take)
                begin
                    rem_reg <= 42'(rem_sh - 43'(den_reg));
                    q_reg   <= {q_reg[TAB_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem_sh[41:0];
                    q_reg   <= {q_reg[TAB_W-2:0], 1'b0};
                end
            end
            G_PUT:
            begin
                a_reg    <= 61'(e_reg);
                acch_reg <= '0;
                accl_reg <= '0;
                if (k_reg == KW'(TANH_TABLE_SIZE))
                begin
                    tmax_reg <= q_reg;
                end
            end
            G_MUL:
            begin
                a_reg <= a_reg << 1;
                if (R_HI[cnt_reg[4:0]])
                begin
                    acch_reg <= acch_reg + a_reg;
                end
                if (R_LO[cnt_reg[4:0]])
                begin
                    accl_reg <= accl_reg + a_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign tab_wr.we   = st_reg == G_PUT;
    assign tab_wr.data = q_reg;
    assign tab_k       = k_reg;
    assign tmax        = tmax_reg;
    assign done        = st_reg == G_DONE;
endmodule

@@ hdl/sfd_lane.sv @@
// one channel: delay store, damping low-pass, tanh feedback and dry/wet mix
module sfd_lane import sfd_pkg::*; #(
    parameter int MAX_DELAY       = 262144,
    parameter int TANH_TABLE_SIZE = 1024
) (
    input  logic                                            clk,
    input  logic                                            rst_n,
    input  lane_ctrl_t                                      ctrl,
    input  logic [(MAX_DELAY > 1 ? $clog2(MAX_DELAY) : 1)-1:0] rd_addr,
    input  logic [(MAX_DELAY > 1 ? $clog2(MAX_DELAY) : 1)-1:0] wr_addr,
    input  logic signed [SAMPLE_W-1:0]                      x,
    input  tab_wr_t                                         tab_wr,
    input  logic [$clog2(TANH_TABLE_SIZE+1)-1:0]            tab_k,
    input  logic [TAB_W-1:0]                                tmax,
    output logic signed [SAMPLE_W-1:0]                      y
);
    localparam int KW     = $clog2(TANH_TABLE_SIZE + 1);
    localparam int PW     = 25 + KW;
    localparam int EVEN_D = TANH_TABLE_SIZE / 2 + 1;
    localparam int ODD_D  = (TANH_TABLE_SIZE + 1) / 2;
    localparam int EAW    = $clog2(EVEN_D);
    localparam int OAW    = $clog2(ODD_D);

    localparam logic signed [28:0] LP_HI  = 29'sd33554431;
    localparam logic signed [28:0] LP_LO  = -29'sd33554432;
    localparam logic signed [28:0] OUT_HI = 29'sd8388607;
    localparam logic signed [28:0] OUT_LO = -29'sd8388608;

    logic [STORE_W-1:0] dly_q;
    logic [TAB_W-1:0]   ev_q;
    logic [TAB_W-1:0]   od_q;

    logic signed [SAMPLE_W-1:0] x_reg;
    logic signed [STORE_W-1:0]  lp_reg;
    logic signed [STORE_W-1:0]  delayed_reg;
    logic signed [43:0]         plp_reg;
    logic signed [41:0]         pa_reg;
    logic signed [43:0]         pb_reg;
    logic signed [42:0]         pf_reg;
    logic signed [SAMPLE_W-1:0] y_reg;
    logic                       neg_reg;
    logic                       sat_reg;
    logic                       iodd_reg;
    logic [24:0]                f_reg;
    logic [TAB_W-1:0]           lo_reg;
    logic [48:0]                pt_reg;

    // read of the delayed value and low-pass step
    logic signed [STORE_W-1:0] delayed_w;
    logic signed [26:0]        diff_w;
    logic signed [16:0]        coef_s;
    logic signed [43:0]        lpt_w;
    logic signed [27:0]        lpinc_w;
    logic signed [28:0]        lpsum_w;
    logic signed [STORE_W-1:0] lpsat_w;

    assign delayed_w = ctrl.vld ? $signed(dly_q) : '0;
    assign diff_w    = 27'(delayed_w) - 27'(lp_reg);
    assign coef_s    = $signed({1'b0, ctrl.coeff});
    assign lpt_w     = plp_reg + 44'sd32768;
    assign lpinc_w   = $signed(lpt_w[43:16]);
    assign lpsum_w   = 29'(lp_reg) + 29'(lpinc_w);
    assign lpsat_w   = (lpsum_w > LP_HI) ? STORE_W'(LP_HI) :
                       (lpsum_w < LP_LO) ? STORE_W'(LP_LO) : lpsum_w[STORE_W-1:0];

    // dry/wet mix
    logic signed [17:0] wet_s;
    logic signed [17:0] dry_s;
    logic signed [44:0] ms_w;
    logic signed [28:0] mr_w;

    assign wet_s = $signed({1'b0, ctrl.mix});
    assign dry_s = $signed({1'b0, 17'(UNITY - int'(ctrl.mix))});
    assign ms_w  = 45'(pa_reg) + 45'(pb_reg) + 45'sd32768;
    assign mr_w  = $signed(ms_w[44:16]);

    // feedback argument and table lookup
    logic signed [16:0] fb_s;
    logic signed [42:0] at_w;
    logic signed [26:0] arg_w;
    logic [26:0]        mag_w;
    logic               sat_w;
    logic [PW-1:0]      p_w;
    logic [KW-1:0]      idx_w;
    logic [KW:0]        evi_w;

    assign fb_s  = $signed({1'b0, ctrl.fb});
    assign at_w  = pf_reg + 43'sd32768;
    assign arg_w = $signed(at_w[42:16]);
    assign mag_w = arg_w[26] ? 27'(-arg_w) : 27'(arg_w);
    assign sat_w = mag_w[26] | mag_w[25];
    assign p_w   = PW'(mag_w[24:0]) * PW'(TANH_TABLE_SIZE);
    assign idx_w = sat_w ? '0 : p_w[PW-1:25];
    assign evi_w = {1'b0, idx_w} + (KW+1)'(1);

    // interpolation and write-back value
    logic [TAB_W-1:0]          lo_w;
    logic [TAB_W-1:0]          hi_w;
    logic [TAB_W-1:0]          dlt_w;
    logic [49:0]               tr_w;
    logic [24:0]               tsum_w;
    logic [TAB_W-1:0]          tv_w;
    logic signed [STORE_W-1:0] tvs_w;
    logic signed [STORE_W-1:0] wdata_w;

    assign lo_w    = iodd_reg ? od_q : ev_q;
    assign hi_w    = iodd_reg ? ev_q : od_q;
    assign dlt_w   = (hi_w >= lo_w) ? hi_w - lo_w : '0;
    assign tr_w    = 50'(pt_reg) + (50'(1) << 24);
    assign tsum_w  = 25'(lo_reg) + tr_w[49:25];
    assign tv_w    = sat_reg ? tmax : tsum_w[TAB_W-1:0];
    assign tvs_w   = neg_reg ? -$signed({2'b00, tv_w}) : $signed({2'b00, tv_w});
    assign wdata_w = STORE_W'(x_reg) + tvs_w;

    sfd_ram #(
        .WIDTH (STORE_W),
        .DEPTH (MAX_DELAY)
    ) u_store (
        .clk   (clk),
        .we    (ctrl.wr_en),
        .waddr (wr_addr),
        .wdata (wdata_w),
        .re    (ctrl.rd_en),
        .raddr (rd_addr),
        .rdata (dly_q)
    );

    sfd_ram #(
        .WIDTH (TAB_W),
        .DEPTH (EVEN_D)
    ) u_tab_even (
        .clk   (clk),
        .we    (tab_wr.we & ~tab_k[0]),
        .waddr (EAW'(tab_k >> 1)),
        .wdata (tab_wr.data),
        .re    (ctrl.st_th),
        .raddr (EAW'(evi_w >> 1)),
        .rdata (ev_q)
    );

    sfd_ram #(
        .WIDTH (TAB_W),
        .DEPTH (ODD_D)
    ) u_tab_odd (
        .clk   (clk),
        .we    (tab_wr.we & tab_k[0]),
        .waddr (OAW'(tab_k >> 1)),
        .wdata (tab_wr.data),
        .re    (ctrl.st_th),
        .raddr (OAW'(idx_w >> 1)),
        .rdata (od_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lp_reg <= '0;
        end
        else if (ctrl.st_lp)
        begin
            lp_reg <= lpsat_w;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.rd_en)
        begin
            x_reg <= x;
        end
        if (ctrl.st_rd)
        begin
            delayed_reg <= delayed_w;
            plp_reg     <= 44'(diff_w) * 44'(coef_s);
        end
        if (ctrl.st_lp)
        begin
            pa_reg <= 42'(x_reg) * 42'(dry_s);
            pb_reg <= 44'(delayed_reg) * 44'(wet_s);
        end
        if (ctrl.st_fb)
        begin
            pf_reg <= 43'(lp_reg) * 43'(fb_s);
            y_reg  <= (mr_w > OUT_HI) ? SAMPLE_W'(OUT_HI) :
                      (mr_w < OUT_LO) ? SAMPLE_W'(OUT_LO) : mr_w[SAMPLE_W-1:0];
        end
        if (ctrl.st_th)
        begin
            neg_reg  <= arg_w[26];
            sat_reg  <= sat_w;
            iodd_reg <= idx_w[0];
            f_reg    <= p_w[24:0];
        end
        if (ctrl.st_ip)
        begin
            lo_reg <= lo_w;
            pt_reg <= 49'(dlt_w) * 49'(f_reg);
        end
    end

    assign y = y_reg;
endmodule

@@ hdl/stereo_feedback_delay_damped.sv @@
// top level: configuration, item sequencer, channel lanes and output merge
//
//  channel   dir  word                      accepted when
//  din       in   left_in, right_in         din.valid & din.ready
//  dout      out  left_out, right_out       dout.valid & dout.ready
//  cfg       in   cfg_index, cfg_data       cfg_we
//
//  one item at a time, din.ready low until its result is written: the lane chain
//  of delay-store read, low-pass multiply, feedback multiply, table read and
//  interpolation multiply; after reset the tanh table is built, with
//  din.ready low; config writes are taken
//  a result waiting in the output register holds the lanes in their last step
module stereo_feedback_delay_damped import sfd_pkg::*; #(
    parameter int MAX_DELAY       = 262144,
    parameter int NUM_CHANNELS    = 2,
    parameter int TANH_TABLE_SIZE = 1024
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    sfd_in_if.sink               din,
    sfd_out_if.source            dout
);
    localparam int AW = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1;
    localparam int DW = ((AW > CFG_W) ? AW : CFG_W) + 2;
    localparam int KW = $clog2(TANH_TABLE_SIZE + 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RD   = 3'd1;
    localparam logic [2:0] ST_LP   = 3'd2;
    localparam logic [2:0] ST_FB   = 3'd3;
    localparam logic [2:0] ST_TH   = 3'd4;
    localparam logic [2:0] ST_IP   = 3'd5;
    localparam logic [2:0] ST_WR   = 3'd6;

    logic [17:0] delay_reg;
    logic [15:0] fbk_reg;
    logic [16:0] damp_reg;
    logic [16:0] mix_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_reg <= 18'd12000;
            fbk_reg   <= 16'd26214;
            damp_reg  <= 17'd19661;
            mix_reg   <= 17'd22938;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_DELAY:    delay_reg <= cfg_data[17:0];
                CFG_FEEDBACK: fbk_reg   <= cfg_data[15:0];
                CFG_DAMPING:  damp_reg  <= cfg_data[16:0];
                CFG_MIX:      mix_reg   <= cfg_data[16:0];
            endcase
        end
    end

    logic [2:0]    st_reg;
    logic [2:0]    st_next;
    logic [AW-1:0] wp_reg;
    logic          full_reg;
    logic          vld_reg;
    logic [15:0]   coeff_reg;
    logic [15:0]   fb_reg;
    logic [16:0]   mixr_reg;
    logic          ovalid_reg;
    logic signed [SAMPLE_W-1:0] left_reg;
    logic signed [SAMPLE_W-1:0] right_reg;

    logic tab_done;
    logic accept;
    logic out_free;
    logic finish;

    assign out_free = !ovalid_reg || dout.ready;
    assign din.ready = (st_reg == ST_IDLE) && tab_done;
    assign accept   = din.valid && din.ready;
    assign finish   = (st_reg == ST_WR) && out_free;

    // clamped settings
    logic [16:0] dmp_w;
    logic [15:0] fbc_w;
    logic [16:0] mixc_w;
    logic [32:0] cprod_w;
    logic [32:0] cround_w;

    assign dmp_w    = (damp_reg > 17'(UNITY)) ? 17'(UNITY) : damp_reg;
    assign fbc_w    = (fbk_reg > 16'(FB_MAX)) ? 16'(FB_MAX) : fbk_reg;
    assign mixc_w   = (mix_reg > 17'(UNITY)) ? 17'(UNITY) : mix_reg;
    assign cprod_w  = 33'(dmp_w) * 33'(DAMP_SCALE);
    assign cround_w = cprod_w + 33'd32768;

    // read address behind the write pointer
    logic [DW-1:0] draw_w;
    logic [DW-1:0] deff_w;
    logic [DW-1:0] wpw_w;
    logic [DW-1:0] rdw_w;
    logic [AW-1:0] rd_w;

    assign draw_w = DW'(delay_reg);
    assign deff_w = (draw_w == '0) ? DW'(1) :
                    (draw_w >= DW'(MAX_DELAY)) ? DW'(MAX_DELAY - 1) : draw_w;
    assign wpw_w  = DW'(wp_reg);
    assign rdw_w  = (wpw_w >= deff_w) ? wpw_w - deff_w : wpw_w + DW'(MAX_DELAY) - deff_w;
    assign rd_w   = rdw_w[AW-1:0];

    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            ST_IDLE: if (accept) st_next = ST_RD;
            ST_RD:   st_next = ST_LP;
            ST_LP:   st_next = ST_FB;
            ST_FB:   st_next = ST_TH;
            ST_TH:   st_next = ST_IP;
            ST_IP:   st_next = ST_WR;
            ST_WR:   if (out_free) st_next = ST_IDLE;
            default: st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg     <= ST_IDLE;
            wp_reg     <= '0;
            full_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            if (finish)
            begin
                if (wp_reg == AW'(MAX_DELAY - 1))
                begin
                    wp_reg   <= '0;
                    full_reg <= 1'b1;
                end
                else
                begin
                    wp_reg <= wp_reg + AW'(1);
                end
            end
            if (finish)
            begin
                ovalid_reg <= 1'b1;
            end
            else if (dout.ready)
            begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            vld_reg   <= full_reg || (rd_w < wp_reg);
            coeff_reg <= cround_w[31:16];
            fb_reg    <= fbc_w;
            mixr_reg  <= mixc_w;
        end
    end

    lane_ctrl_t ctrl;

    assign ctrl.rd_en = accept;
    assign ctrl.st_rd = st_reg == ST_RD;
    assign ctrl.st_lp = st_reg == ST_LP;
    assign ctrl.st_fb = st_reg == ST_FB;
    assign ctrl.st_th = st_reg == ST_TH;
    assign ctrl.st_ip = st_reg == ST_IP;
    assign ctrl.wr_en = finish;
    assign ctrl.vld   = vld_reg;
    assign ctrl.coeff = coeff_reg;
    assign ctrl.fb    = fb_reg;
    assign ctrl.mix   = mixr_reg;

    tab_wr_t          tab_wr;
    logic [KW-1:0]    tab_k;
    logic [TAB_W-1:0] tmax;

    sfd_tanh_gen #(
        .TANH_TABLE_SIZE (TANH_TABLE_SIZE)
    ) u_gen (
        .clk    (clk),
        .rst_n  (rst_n),
        .tab_wr (tab_wr),
        .tab_k  (tab_k),
        .tmax   (tmax),
        .done   (tab_done)
    );

    logic signed [SAMPLE_W-1:0] lane_y [NUM_CHANNELS];

    for (genvar c = 0; c < NUM_CHANNELS; c++)
    begin : g_lane
        sfd_lane #(
            .MAX_DELAY       (MAX_DELAY),
            .TANH_TABLE_SIZE (TANH_TABLE_SIZE)
        ) u_lane (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctrl    (ctrl),
            .rd_addr (rd_w),
            .wr_addr (wp_reg),
            .x       ((c == 0) ? din.left_in : din.right_in),
            .tab_wr  (tab_wr),
            .tab_k   (tab_k),
            .tmax    (tmax),
            .y       (lane_y[c])
        );
    end

    // merge of the lane results into the output word
    logic signed [SAMPLE_W-1:0] right_w;

    if (NUM_CHANNELS > 1)
    begin : g_right
        assign right_w = lane_y[NUM_CHANNELS-1];
    end
    else
    begin : g_mono
        assign right_w = '0;
    end

    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            left_reg  <= lane_y[0];
            right_reg <= right_w;
        end
    end

    assign dout.valid     = ovalid_reg;
    assign dout.left_out  = left_reg;
    assign dout.right_out = right_reg;

    a_no_accept_in_build: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> tab_done)
        else $error("word taken before the tanh table was built");

    a_busy_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg != ST_IDLE) |-> !din.ready)
        else $error("input ready while an item is in the lanes");

    a_full_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        full_reg |=> full_reg)
        else $error("delay store fill mark dropped");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == ST_WR && !out_free) |=> (st_reg == ST_WR && $stable(wp_reg)))
        else $error("lanes left the write step while the output word waits");
endmodule

@@ bench/sfd_mix_monitor.sv @@
// monitor of the stereo feedback delay: predicts every mixed pair and compares it
`timescale 1ns / 1ps
module sfd_mix_monitor import sfd_pkg::*; #(
    parameter int MAX_DELAY       = 262144,
    parameter int TANH_TABLE_SIZE = 1024
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    sfd_in_if                    din,
    sfd_out_if                   dout,
    output int                   errors,
    output int                   pending
);

    typedef struct {
        logic signed [SAMPLE_W-1:0] left;
        logic signed [SAMPLE_W-1:0] right;
    } mixed_pair_t;

    mixed_pair_t       mixed_pairs[$];
    longint unsigned   tanh_points[TANH_TABLE_SIZE+1];
    int                echo_store[2][MAX_DELAY];
    longint            damped[2];
    int unsigned       wr_ptr;
    logic [17:0]       delay_reg;
    logic [15:0]       fb_reg;
    logic [16:0]       damp_reg;
    logic [16:0]       mix_reg;

    function automatic longint round_q16(longint x);
        return (x + 64'sd32768) >>> 16;
    endfunction

    function automatic longint clip(longint x, int w);
        longint hi;
        hi = (64'sd1 <<< (w - 1)) - 1;
        return x > hi ? hi : (x < -hi - 1 ? -hi - 1 : x);
    endfunction

    function automatic void build_tanh();
        longint unsigned one40, term, r, e, d, num, den;
        one40 = 64'd1 << 40;
        term  = one40;
        r     = one40;
        e     = one40;
        for (int n = 1; n <= 24; n++)
        begin
            d    = longint'(TANH_TABLE_SIZE) * n;
            term = (term * 8 + d / 2) / d;
            if (n % 2 == 1)
                r = r - term;
            else
                r = r + term;
        end
        for (int k = 0; k <= TANH_TABLE_SIZE; k++)
        begin
            num = one40 - e;
            den = one40 + e;
            tanh_points[k] = ((num << 23) + den / 2) / den;
            e = (e * (r >> 20) + ((e * (r & 64'hFFFFF)) >> 20)) >> 20;
        end
    endfunction

    function automatic longint soft_clip(longint a);
        longint unsigned m, p, i, f, lo, hi, dlt, y;
        m = a < 0 ? longint'(-a) : longint'(a);
        if (m >= (64'd1 << 25))
            y = tanh_points[TANH_TABLE_SIZE];
        else
        begin
            p = m * TANH_TABLE_SIZE;
            i = p >> 25;
            f = p & ((64'd1 << 25) - 1);
            if (i >= TANH_TABLE_SIZE)
                y = tanh_points[TANH_TABLE_SIZE];
            else
            begin
                lo  = tanh_points[i];
                hi  = tanh_points[i + 1];
                dlt = hi >= lo ? hi - lo : 0;
                y   = lo + ((dlt * f + (64'd1 << 24)) >> 25);
            end
        end
        return a < 0 ? -longint'(y) : longint'(y);
    endfunction

    function automatic mixed_pair_t predict_pair(logic signed [SAMPLE_W-1:0] l,
                                                 logic signed [SAMPLE_W-1:0] r);
        mixed_pair_t res;
        longint      dmp, fb, mix, coeff, x, dly, lp, arg, y;
        int unsigned dl, rd;
        dmp   = damp_reg > UNITY ? UNITY : damp_reg;
        fb    = fb_reg > FB_MAX ? FB_MAX : fb_reg;
        mix   = mix_reg > UNITY ? UNITY : mix_reg;
        coeff = round_q16(dmp * DAMP_SCALE);
        dl    = delay_reg == 0 ? 1 : delay_reg;
        if (dl >= MAX_DELAY)
            dl = MAX_DELAY - 1;
        rd = (wr_ptr + MAX_DELAY - dl) % MAX_DELAY;
        for (int ch = 0; ch < 2; ch++)
        begin
            x   = ch == 0 ? longint'(l) : longint'(r);
            dly = echo_store[ch][rd];
            lp  = clip(damped[ch] + round_q16(coeff * (dly - damped[ch])), STORE_W);
            damped[ch] = lp;
            arg = round_q16(lp * fb);
            echo_store[ch][wr_ptr] = int'(clip(x + soft_clip(arg), STORE_W));
            y = clip(round_q16(x * (UNITY - mix) + dly * mix), SAMPLE_W);
            if (ch == 0)
                res.left = y[SAMPLE_W-1:0];
            else
                res.right = y[SAMPLE_W-1:0];
        end
        wr_ptr = (wr_ptr + 1) % MAX_DELAY;
        return res;
    endfunction

    initial
    begin
        build_tanh();
    end

    always @(posedge clk or negedge rst_n)
    begin
        mixed_pair_t want;
        if (!rst_n)
        begin
            for (int ch = 0; ch < 2; ch++)
                for (int k = 0; k < MAX_DELAY; k++)
                    echo_store[ch][k] = 0;
            damped    = '{0, 0};
            wr_ptr    = 0;
            delay_reg = 18'd12000;
            fb_reg    = 16'd26214;
            damp_reg  = 17'd19661;
            mix_reg   = 17'd22938;
            errors    = 0;
            mixed_pairs.delete();
            pending   = 0;
        end
        else
        begin
            if (dout.valid && dout.ready)
            begin
                if (mixed_pairs.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected word expected none actual %0d %0d",
                             $time, dout.left_out, dout.right_out);
                end
                else
                begin
                    want = mixed_pairs.pop_front();
                    if (want.left !== dout.left_out)
                    begin
                        errors++;
                        $display("%0t: left_out expected %0d actual %0d",
                                 $time, want.left, dout.left_out);
                    end
                    if (want.right !== dout.right_out)
                    begin
                        errors++;
                        $display("%0t: right_out expected %0d actual %0d",
                                 $time, want.right, dout.right_out);
                    end
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_DELAY:    delay_reg = cfg_data[17:0];
                    CFG_FEEDBACK: fb_reg    = cfg_data[15:0];
                    CFG_DAMPING:  damp_reg  = cfg_data[16:0];
                    CFG_MIX:      mix_reg   = cfg_data[16:0];
                    default:      ;
                endcase
            end
            if (din.valid && din.ready)
                mixed_pairs.push_back(predict_pair(din.left_in, din.right_in));
            pending = mixed_pairs.size();
        end
    end

endmodule

@@ bench/tb.sv @@
// top of the stereo feedback delay bench: stimulus, flow control and verdict
`timescale 1ns / 1ps
module tb;
    import sfd_pkg::*;

    localparam int PHASES     = 6;
    localparam int PER_PHASE  = 75;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    int                   errors;
    int                   pending;
    int                   send_idle;
    int                   recv_idle;
    bit                   hold_req;

    sfd_in_if  din_ch();
    sfd_out_if dout_ch();

    stereo_feedback_delay_damped u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .din       (din_ch.sink),
        .dout      (dout_ch.source)
    );

    sfd_mix_monitor u_monitor (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .din       (din_ch),
        .dout      (dout_ch),
        .errors    (errors),
        .pending   (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic send_pair(logic [SAMPLE_W-1:0] l, logic [SAMPLE_W-1:0] r);
        while ($urandom_range(99) < send_idle)
        begin
            din_ch.valid <= 1'b0;
            @(posedge clk);
        end
        din_ch.valid    <= 1'b1;
        din_ch.left_in  <= l;
        din_ch.right_in <= r;
        forever
        begin
            @(negedge clk);
            if (din_ch.ready)
                break;
        end
        @(posedge clk);
    endtask

    function automatic logic [SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(5))
            0:       return 24'(24'h7FFFFF - $urandom_range(3));
            1:       return 24'(24'h800000 + $urandom_range(3));
            2:       return 24'($urandom_range(255) - 128);
            default: return 24'($urandom());
        endcase
    endfunction

    // receiver, with one long hold when asked
    initial
    begin
        dout_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                dout_ch.ready <= 1'b0;
                repeat (300) @(posedge clk);
                hold_req = 1'b0;
            end
            dout_ch.ready <= $urandom_range(99) >= recv_idle;
        end
    end

    initial
    begin
        logic [CFG_W-1:0] dly, fbk, dmp, mix;
        din_ch.valid    <= 1'b0;
        din_ch.left_in  <= '0;
        din_ch.right_in <= '0;
        cfg_we          <= 1'b0;
        cfg_index       <= CFG_DELAY;
        cfg_data        <= '0;
        send_idle       = 26;
        recv_idle       = 64;
        hold_req        = 1'b0;
        rst_n           <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int ph = 0; ph < PHASES; ph++)
        begin
            if (ph > 0)
            begin
                wait (pending == 0);
                repeat (20) @(posedge clk);
            end
            send_idle = ph < 2 ? 26 : (ph < 4 ? 64 : 0);
            recv_idle = ph < 2 ? 64 : (ph < 4 ? 26 : 0);
            case (ph)
                0:
                begin
                    dly = 18'd0; fbk = 18'hFFFF; dmp = 18'h1FFFF; mix = 18'h1FFFF;
                end
                1:
                begin
                    dly = 18'd1; fbk = 18'(FB_MAX); dmp = 18'd0; mix = 18'(UNITY);
                end
                2:
                begin
                    dly = 18'h3FFFF; fbk = 18'd0; dmp = 18'(UNITY); mix = 18'd0;
                end
                default:
                begin
                    dly = 18'($urandom_range(60, 1));
                    fbk = 18'($urandom_range(16'hFFFF));
                    dmp = 18'($urandom_range(17'h1FFFF));
                    mix = 18'($urandom_range(17'h1FFFF));
                end
            endcase
            write_reg(CFG_DELAY, dly);
            write_reg(CFG_FEEDBACK, fbk);
            write_reg(CFG_DAMPING, dmp);
            write_reg(CFG_MIX, mix);
            if (ph == 0)
            begin
                send_pair(24'h000000, 24'h000000);
                send_pair(24'h7FFFFF, 24'h7FFFFF);
                send_pair(24'h800000, 24'h800000);
                send_pair(24'h7FFFFF, 24'h800000);
                send_pair(24'h800000, 24'h7FFFFF);
                send_pair(24'h000001, 24'hFFFFFF);
                send_pair(24'hFFFFFF, 24'h000001);
                send_pair(24'h555555, 24'hAAAAAA);
                send_pair(24'hAAAAAA, 24'h555555);
                for (int k = 0; k < 12; k++)
                    send_pair(k[0] ? 24'h7FFFFF : 24'h800000, k[1] ? 24'h7FFFFF : 24'h800000);
            end
            if (ph == 1)
                hold_req = 1'b1;
            for (int k = 0; k < PER_PHASE; k++)
                send_pair(rand_sample(), rand_sample());
            din_ch.valid <= 1'b0;
        end
        wait (pending == 0);
        repeat (30) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        #8ms;
        $display("tb: failure");
        $finish;
    end

endmodule
